### hdl/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check an implication from one edge to the next, outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ats_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

    localparam int POSITION_BITS_DEF     = 16;
    localparam int KEYWORD_MAX_CHARS_DEF = 4;
    localparam int KW_COUNT              = 62;
    localparam int PREFIX_BITS_MAX       = 64;
    localparam int WLEN_BITS_MAX         = 4;
    localparam int RES_DEPTH             = 4;

    localparam logic [2:0] KIND_TEXT    = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_KEYWORD = 3'd2;
    localparam logic [2:0] KIND_NUMBER  = 3'd3;
    localparam logic [2:0] KIND_STRING  = 3'd4;
    localparam logic [2:0] KIND_PUNCT   = 3'd5;
    localparam logic [2:0] KIND_EOL     = 3'd6;
    localparam logic [2:0] KIND_EOI     = 3'd7;

    typedef struct packed {
        logic [7:0] ch;
        logic       at_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  keyword_index;
        logic [7:0]  text_char;
        logic [15:0] start_line;
        logic [15:0] start_col;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] index;
    } kw_match_t;

    // Keywords in sorted order, packed right-justified one byte per char.
    localparam logic [31:0] KW_WORDS [KW_COUNT] = '{
        "a", "adc", "add", "af", "and", "b", "bc", "bit", "c", "call",
        "ccf", "cp", "cpl", "d", "daa", "db", "de", "dec", "di", "e",
        "ei", "f", "h", "halt", "hl", "inc", "jp", "jr", "l", "ld",
        "ldd", "ldi", "nc", "nop", "nz", "or", "pop", "push", "res", "ret",
        "reti", "rl", "rla", "rlc", "rlca", "rr", "rra", "rrc", "rrca", "rst",
        "sbc", "scf", "set", "sla", "sp", "sra", "srl", "stop", "sub", "swap",
        "xor", "z"
    };

    function automatic logic [WLEN_BITS_MAX-1:0] kw_length(input logic [31:0] w);
        logic [WLEN_BITS_MAX-1:0] n;
        if (w[31:24] != 8'h00) begin
            n = WLEN_BITS_MAX'(4);
        end else if (w[23:16] != 8'h00) begin
            n = WLEN_BITS_MAX'(3);
        end else if (w[15:8] != 8'h00) begin
            n = WLEN_BITS_MAX'(2);
        end else begin
            n = WLEN_BITS_MAX'(1);
        end
        return n;
    endfunction

    function automatic kw_match_t kw_lookup(input logic [PREFIX_BITS_MAX-1:0] prefix,
                                            input logic [WLEN_BITS_MAX-1:0] len);
        kw_match_t m;
        m = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (prefix == PREFIX_BITS_MAX'(KW_WORDS[i]) && len == kw_length(KW_WORDS[i])) begin
                m.hit   = 1'b1;
                m.index = 6'(i);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### hdl/assembler_token_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// Assembler token scanner.
// s_ channel: one source byte per item (s_data.ch), or an end-of-input mark
// (s_data.at_end) that closes any open token and yields an end-of-input item.
// m_ channel: result items (text echo, identifier, keyword, number, string,
// punctuation, end of line, end of input), each with the line and column
// where its token began; last marks the final result of one input item.
// An input item yields zero, one or two results.
// Results are registered into the output queue when the input item is accepted.
// Throughput: one input item per cycle while s_ready is high; the scan state
// and keyword match are one combinational pass, and results go into a
// four-entry output queue. s_ready stays high while the queue has room for two
// results, so a steady stream of single-result items runs at full rate; a stream
// of two-result items fills the queue faster than it drains, and s_ready drops.
// When the receiver stalls, the queue fills and s_ready drops; nothing is lost.
// Reset (aresetn low, synchronous) empties the queue and returns the scanner
// to line 1, column 1, between tokens; s_ready is low while reset is held.
module assembler_token_scanner #(
    parameter int POSITION_BITS     = ats_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_CHARS = ats_pkg::KEYWORD_MAX_CHARS_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire ats_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output ats_pkg::out_item_t      m_data
);

    `include "assert_macros.svh"

    localparam int PW     = 8 * KEYWORD_MAX_CHARS;
    localparam int LW     = $clog2(KEYWORD_MAX_CHARS + 2);
    localparam int OW     = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam int DEPTH  = ats_pkg::RES_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_WORD   = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_STRING = 4'b1000
    } mode_t;

    function automatic logic [15:0] out_pos(input logic [POSITION_BITS-1:0] v);
        logic [OW-1:0] ext;
        ext = OW'(v);
        return (ext > OW'(17'h0FFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic ats_pkg::out_item_t mk_item(input logic [2:0] kind,
                                                   input logic [5:0] kwi,
                                                   input logic [7:0] tc,
                                                   input logic [POSITION_BITS-1:0] ln,
                                                   input logic [POSITION_BITS-1:0] cl);
        ats_pkg::out_item_t r;
        r.kind          = kind;
        r.keyword_index = kwi;
        r.text_char     = tc;
        r.start_line    = out_pos(ln);
        r.start_col     = out_pos(cl);
        r.last          = 1'b0;
        return r;
    endfunction

    mode_t                    mode_reg, mode_next;
    logic [PW-1:0]            prefix_reg, prefix_next;
    logic [LW-1:0]            wlen_reg, wlen_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] tline_reg, tline_next;
    logic [POSITION_BITS-1:0] tcol_reg, tcol_next;

    ats_pkg::out_item_t       fifo_reg [DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    logic                     s_accept, m_accept;
    logic [7:0]               c;
    logic                     cont;
    ats_pkg::kw_match_t       kw;
    ats_pkg::out_item_t       close_res, cl_res, mn_res, e0, e1;
    logic                     close_ok, cl_vld, mn_vld;
    logic [1:0]               push_n;

    assign s_ready  = aresetn && (count_reg <= CNT_W'(DEPTH - 2));
    assign s_accept = s_valid && s_ready;
    assign m_valid  = (count_reg != '0);
    assign m_accept = m_valid && m_ready;
    assign m_data   = fifo_reg[rd_ptr_reg];
    assign c        = s_data.ch;

    // Token that the current mode would close.
    always_comb begin
        kw        = ats_pkg::kw_lookup(ats_pkg::PREFIX_BITS_MAX'(prefix_reg),
                                       ats_pkg::WLEN_BITS_MAX'(wlen_reg));
        close_ok  = (mode_reg != MODE_IDLE);
        close_res = mk_item(ats_pkg::KIND_STRING, 6'd0, 8'd0, tline_reg, tcol_reg);
        unique case (mode_reg)
            MODE_WORD: begin
                if (kw.hit && wlen_reg <= LW'(KEYWORD_MAX_CHARS)) begin
                    close_res = mk_item(ats_pkg::KIND_KEYWORD, kw.index, 8'd0,
                                        tline_reg, tcol_reg);
                end else begin
                    close_res = mk_item(ats_pkg::KIND_IDENT, 6'd0, 8'd0, tline_reg, tcol_reg);
                end
            end
            MODE_NUMBER: close_res = mk_item(ats_pkg::KIND_NUMBER, 6'd0, 8'd0,
                                             tline_reg, tcol_reg);
            MODE_STRING: close_res = mk_item(ats_pkg::KIND_STRING, 6'd0, 8'd0,
                                             tline_reg, tcol_reg);
            MODE_IDLE:   close_res = mk_item(ats_pkg::KIND_STRING, 6'd0, 8'd0,
                                             tline_reg, tcol_reg);
            default:     close_res = mk_item(ats_pkg::KIND_STRING, 6'd0, 8'd0,
                                             tline_reg, tcol_reg);
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        wlen_next   = wlen_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        cl_vld      = 1'b0;
        cl_res      = close_res;
        mn_vld      = 1'b0;
        mn_res      = mk_item(ats_pkg::KIND_TEXT, 6'd0, c, tline_reg, tcol_reg);
        cont        = (mode_reg == MODE_STRING)
                   || (mode_reg == MODE_WORD && (is_alnum(c) || c == "_"))
                   || (mode_reg == MODE_NUMBER && (is_xdigit(c) || c == "x"));

        if (s_accept) begin
            if (s_data.at_end) begin
                cl_vld    = close_ok;
                mn_vld    = 1'b1;
                mn_res    = mk_item(ats_pkg::KIND_EOI, 6'd0, 8'd0, line_reg, col_reg);
                mode_next = MODE_IDLE;
            end else begin
                if (mode_reg == MODE_STRING && c == "\"") begin
                    cl_vld    = 1'b1;
                    mode_next = MODE_IDLE;
                end else if (cont) begin
                    mn_vld = 1'b1;
                    if (mode_reg == MODE_WORD) begin
                        if (wlen_reg < LW'(KEYWORD_MAX_CHARS)) begin
                            prefix_next = {prefix_reg[PW-9:0], c};
                            wlen_next   = wlen_reg + LW'(1);
                        end else begin
                            wlen_next = LW'(KEYWORD_MAX_CHARS + 1);
                        end
                    end
                end else begin
                    // Close whatever is open, then treat the byte as fresh.
                    cl_vld    = close_ok;
                    mode_next = MODE_IDLE;
                    priority if (c == " " || c == "\t") begin
                        mn_vld = 1'b0;
                    end else if (c == "\"") begin
                        mode_next   = MODE_STRING;
                        tline_next  = line_reg;
                        tcol_next   = col_reg;
                        prefix_next = '0;
                        wlen_next   = '0;
                    end else if (c == "(" || c == ")" || c == "+" || c == ","
                              || c == ":" || c == ".") begin
                        mn_vld = 1'b1;
                        mn_res = mk_item(ats_pkg::KIND_PUNCT, 6'd0, c, line_reg, col_reg);
                    end else if (c == 8'h00 || c == "\n" || c == "\r") begin
                        mn_vld = 1'b1;
                        mn_res = mk_item(ats_pkg::KIND_EOL, 6'd0, 8'd0, line_reg, col_reg);
                    end else if (is_digit(c) || c == "-") begin
                        mode_next   = MODE_NUMBER;
                        tline_next  = line_reg;
                        tcol_next   = col_reg;
                        prefix_next = '0;
                        wlen_next   = '0;
                        mn_vld      = 1'b1;
                        mn_res      = mk_item(ats_pkg::KIND_TEXT, 6'd0, c, line_reg, col_reg);
                    end else begin
                        mode_next   = MODE_WORD;
                        tline_next  = line_reg;
                        tcol_next   = col_reg;
                        prefix_next = PW'(c);
                        wlen_next   = LW'(1);
                        mn_vld      = 1'b1;
                        mn_res      = mk_item(ats_pkg::KIND_TEXT, 6'd0, c, line_reg, col_reg);
                    end
                end

                // Advance the position, saturating.
                if (c == "\n") begin
                    if (line_reg != POS_MAX) begin
                        line_next = line_reg + POS_ONE;
                    end
                    col_next = POS_ONE;
                end else if (col_reg != POS_MAX) begin
                    col_next = col_reg + POS_ONE;
                end
            end
        end
    end

    // Pack the results of this item into queue order and mark the final one.
    always_comb begin
        push_n = 2'(cl_vld) + 2'(mn_vld);
        e0     = cl_vld ? cl_res : mn_res;
        e1     = mn_res;
        e1.last = 1'b1;
        e0.last = (push_n == 2'd1);
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(m_accept);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(m_accept);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            prefix_reg <= '0;
            wlen_reg   <= '0;
            line_reg   <= POS_ONE;
            col_reg    <= POS_ONE;
            tline_reg  <= POS_ONE;
            tcol_reg   <= POS_ONE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            wlen_reg   <= wlen_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= e0;
        end
        if (push_n == 2'd2) begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= e1;
        end
    end

    `ASSERT_CLK(a_no_overflow, aclk, aresetn,
        !s_accept || ((CNT_W + 1)'(count_reg) + (CNT_W + 1)'(push_n) <= (CNT_W + 1)'(DEPTH)),
        "result queue overflow")
    `ASSERT_NEXT(a_end_goes_idle, aclk, aresetn, s_accept && s_data.at_end,
        mode_reg == MODE_IDLE && count_reg != '0, "end of input left scanner busy")
    `ASSERT_CLK(a_pos_nonzero, aclk, aresetn,
        line_reg != '0 && col_reg != '0, "position counter reached zero")
    `ASSERT_NEXT(a_pop_moves_head, aclk, aresetn, m_accept,
        rd_ptr_reg == $past(rd_ptr_reg) + PTR_W'(1), "read pointer did not advance")

endmodule

`default_nettype wire

### bench/tb_assembler_token_scanner.sv
`timescale 1ns / 1ps

typedef enum logic [3:0] {
    SCAN_IDLE   = 4'b0001,
    SCAN_WORD   = 4'b0010,
    SCAN_NUMBER = 4'b0100,
    SCAN_STRING = 4'b1000
} scan_state_e;

class token_tracker;
    localparam int KEPT_CHARS = 4;

    string              keywords [62];
    scan_state_e        state;
    string              word_text;
    int                 word_len;
    logic [15:0]        line_no;
    logic [15:0]        col_no;
    logic [15:0]        tok_line;
    logic [15:0]        tok_col;
    ats_pkg::out_item_t tokens_due [$];
    int                 mismatches;
    int                 checked;
    int                 kind_seen [8];

    function new();
        keywords = '{
            "a", "adc", "add", "af", "and", "b", "bc", "bit", "c", "call",
            "ccf", "cp", "cpl", "d", "daa", "db", "de", "dec", "di", "e",
            "ei", "f", "h", "halt", "hl", "inc", "jp", "jr", "l", "ld",
            "ldd", "ldi", "nc", "nop", "nz", "or", "pop", "push", "res", "ret",
            "reti", "rl", "rla", "rlc", "rlca", "rr", "rra", "rrc", "rrca", "rst",
            "sbc", "scf", "set", "sla", "sp", "sra", "srl", "stop", "sub", "swap",
            "xor", "z"
        };
        state      = SCAN_IDLE;
        word_text  = "";
        word_len   = 0;
        line_no    = 16'd1;
        col_no     = 16'd1;
        tok_line   = 16'd1;
        tok_col    = 16'd1;
        mismatches = 0;
        checked    = 0;
        foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_char(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_number_char(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") || c == "x";
    endfunction

    function void add_token(logic [2:0] kind, logic [5:0] kwi, logic [7:0] tc,
                            logic [15:0] ln, logic [15:0] cl);
        ats_pkg::out_item_t r;
        r.kind          = kind;
        r.keyword_index = kwi;
        r.text_char     = tc;
        r.start_line    = ln;
        r.start_col     = cl;
        r.last          = 1'b0;
        tokens_due.push_back(r);
    endfunction

    function void extend_word(logic [7:0] c);
        if (word_len < KEPT_CHARS) begin
            word_text = $sformatf("%s%c", word_text, c);
            word_len++;
        end else begin
            word_len = KEPT_CHARS + 1;
        end
    endfunction

    function void start_token(scan_state_e mode);
        state     = mode;
        tok_line  = line_no;
        tok_col   = col_no;
        word_text = "";
        word_len  = 0;
    endfunction

    function void close_open();
        int hit;
        hit = -1;
        case (state)
            SCAN_WORD: begin
                if (word_len <= KEPT_CHARS) begin
                    foreach (keywords[i]) begin
                        if (hit < 0 && keywords[i] == word_text) hit = i;
                    end
                end
                if (hit >= 0) begin
                    add_token(ats_pkg::KIND_KEYWORD, 6'(hit), 8'h00, tok_line, tok_col);
                end else begin
                    add_token(ats_pkg::KIND_IDENT, 6'd0, 8'h00, tok_line, tok_col);
                end
            end
            SCAN_NUMBER: add_token(ats_pkg::KIND_NUMBER, 6'd0, 8'h00, tok_line, tok_col);
            SCAN_STRING: add_token(ats_pkg::KIND_STRING, 6'd0, 8'h00, tok_line, tok_col);
            default: ;
        endcase
        state = SCAN_IDLE;
    endfunction

    function void note_char(ats_pkg::in_item_t it);
        logic [7:0] c;
        int first;
        c     = it.ch;
        first = tokens_due.size();
        if (it.at_end) begin
            close_open();
            add_token(ats_pkg::KIND_EOI, 6'd0, 8'h00, line_no, col_no);
        end else begin
            if (state == SCAN_STRING) begin
                if (c == "\"") begin
                    close_open();
                end else begin
                    add_token(ats_pkg::KIND_TEXT, 6'd0, c, tok_line, tok_col);
                end
            end else if (state == SCAN_WORD && is_word_char(c)) begin
                extend_word(c);
                add_token(ats_pkg::KIND_TEXT, 6'd0, c, tok_line, tok_col);
            end else if (state == SCAN_NUMBER && is_number_char(c)) begin
                add_token(ats_pkg::KIND_TEXT, 6'd0, c, tok_line, tok_col);
            end else begin
                // the stopping byte closes the open token, then counts as a fresh byte
                close_open();
                if (c == " " || c == "\t") begin
                end else if (c == "\"") begin
                    start_token(SCAN_STRING);
                end else if (c == "(" || c == ")" || c == "+" || c == "," || c == ":"
                             || c == ".") begin
                    add_token(ats_pkg::KIND_PUNCT, 6'd0, c, line_no, col_no);
                end else if (c == 8'h00 || c == "\n" || c == "\r") begin
                    add_token(ats_pkg::KIND_EOL, 6'd0, 8'h00, line_no, col_no);
                end else begin
                    if (is_digit(c) || c == "-") begin
                        start_token(SCAN_NUMBER);
                    end else begin
                        start_token(SCAN_WORD);
                        extend_word(c);
                    end
                    add_token(ats_pkg::KIND_TEXT, 6'd0, c, tok_line, tok_col);
                end
            end
            if (c == "\n") begin
                if (line_no != 16'hFFFF) line_no++;
                col_no = 16'd1;
            end else if (col_no != 16'hFFFF) begin
                col_no++;
            end
        end
        if (tokens_due.size() > first) tokens_due[tokens_due.size() - 1].last = 1'b1;
    endfunction

    function void check_token(ats_pkg::out_item_t got);
        ats_pkg::out_item_t want;
        kind_seen[got.kind]++;
        checked++;
        if (tokens_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result with nothing expected: kind %0d kw %0d char %02h line %0d col %0d last %0d",
                         $time, got.kind, got.keyword_index, got.text_char, got.start_line,
                         got.start_col, got.last);
            end
            return;
        end
        want = tokens_due.pop_front();
        if (got.kind !== want.kind || got.keyword_index !== want.keyword_index
            || got.text_char !== want.text_char || got.start_line !== want.start_line
            || got.start_col !== want.start_col || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: mismatch: expected kind %0d kw %0d char %02h line %0d col %0d last %0d",
                         $time, want.kind, want.keyword_index, want.text_char,
                         want.start_line, want.start_col, want.last);
                $display("%0t:           got      kind %0d kw %0d char %02h line %0d col %0d last %0d",
                         $time, got.kind, got.keyword_index, got.text_char, got.start_line,
                         got.start_col, got.last);
            end
        end
    endfunction

    function int pending();
        return tokens_due.size();
    endfunction
endclass

module tb_assembler_token_scanner;

    localparam int    IDLE_LIMIT    = 5000;
    localparam int    RANDOM_ITEMS  = 900;
    localparam string WORD_CHARS    =
        "0123456789_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string NUMBER_CHARS  = "0123456789abcdefABCDEFx";

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_style_e;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ats_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ats_pkg::out_item_t m_data;

    token_tracker tracker;
    int           burst_left = 0;
    int           chars_sent = 0;
    int           ends_sent  = 0;
    int           held_cycles = 0;

    assembler_token_scanner uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) tracker.note_char(s_data);
            if (m_valid && m_ready) tracker.check_token(m_data);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
        end
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("assembler_token_scanner verification failed");
        $finish;
    end

    // Receiver: random stretches of open, light and heavy stalls, with a long
    // hold-off now and then so that the output queue fills and s_ready drops.
    initial begin : receiver
        int        seg;
        int        len;
        rx_style_e style;
        seg = 0;
        wait (aresetn === 1'b1);
        forever begin
            seg++;
            if (seg % 24 == 4) begin
                len = $urandom_range(300, 400);
                held_cycles += len;
                repeat (len) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else begin
                len   = $urandom_range(5, 60);
                style = rx_style_e'($urandom_range(0, 2));
                repeat (len) begin
                    @(negedge aclk);
                    case (style)
                        RX_OPEN:  m_ready <= 1'b1;
                        RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                        default:  m_ready <= ($urandom_range(0, 2) == 0);
                    endcase
                end
            end
        end
    end

    task automatic send_item(input logic [7:0] c, input logic eoi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= '{ch: c, at_end: eoi};
        do @(posedge aclk); while (!s_ready);
        if (eoi) ends_sent++;
        else chars_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item(c, 1'b0);
    endtask

    task automatic send_end();
        // the byte rides along but must be ignored
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic string random_word(int lo, int hi);
        string w;
        int    n;
        w = "";
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++) begin
            w = $sformatf("%s%c", w, WORD_CHARS[$urandom_range(i == 0 ? 10 : 0,
                                                               WORD_CHARS.len() - 1)]);
        end
        return w;
    endfunction

    function automatic string random_number();
        string w;
        int    n;
        case ($urandom_range(0, 2))
            0:       w = "0x";
            1:       w = "-";
            default: w = $sformatf("%c", "0" + $urandom_range(0, 9));
        endcase
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
            w = $sformatf("%s%c", w, NUMBER_CHARS[$urandom_range(0, NUMBER_CHARS.len() - 1)]);
        end
        return w;
    endfunction

    function automatic string random_keyword();
        return tracker.keywords[$urandom_range(0, 61)];
    endfunction

    task automatic send_blanks();
        int n;
        n = $urandom_range(0, 2);
        repeat (n) send_char(($urandom_range(0, 3) == 0) ? "\t" : " ");
    endtask

    task automatic send_operand();
        int         n;
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1: send_text(random_keyword());
            2, 3: send_text(random_number());
            4: begin
                send_char("(");
                send_text(random_keyword());
                if ($urandom_range(0, 1) == 0) begin
                    send_char("+");
                    send_text(random_number());
                end
                send_char(")");
            end
            5: begin
                // string with arbitrary bytes; leave it open now and then
                send_char("\"");
                n = $urandom_range(0, 6);
                repeat (n) begin
                    b = 8'($urandom_range(0, 255));
                    send_char(b == "\"" ? "q" : b);
                end
                if ($urandom_range(0, 7) != 0) send_char("\"");
            end
            6: send_text(random_word(1, 8));
            7: send_text({random_keyword(), random_word(1, 3)});
            8: send_char(($urandom_range(0, 1) == 0) ? "." : "+");
            default: send_char(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_random_line();
        int n_ops;
        n_ops = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) begin
            send_text(random_word(1, 6));
            send_char(":");
        end
        send_blanks();
        if ($urandom_range(0, 5) != 0) send_text(random_keyword());
        for (int k = 0; k < n_ops; k++) begin
            if (k > 0) send_char(",");
            send_blanks();
            send_operand();
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 19))
            0:       send_end();
            1:       send_text("\r\n");
            2:       send_char(8'h00);
            default: send_char("\n");
        endcase
    endtask

    initial begin : stimulus
        int base;
        tracker = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // keyword closed by a newline, hex number, string holding zero and
        // newline, over-long word, top byte as a word, open string at end
        send_text("rrca\n");
        send_text("(0xF,");
        send_char("\"");
        send_char(8'h00);
        send_text("\n\"");
        send_text("swap5:\t");
        send_char(8'hFF);
        send_text("\r\"z");
        send_end();
        send_end();

        base = chars_sent + ends_sent;
        while (chars_sent + ends_sent - base < RANDOM_ITEMS) send_random_line();

        send_text("ld (hl),-0x7f \"s\" z9\n");
        send_end();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d characters and %0d end marks; %0d results checked",
                 chars_sent, ends_sent, tracker.checked);
        $display("  %0d keywords, %0d identifiers, %0d numbers, %0d strings, %0d held cycles",
                 tracker.kind_seen[ats_pkg::KIND_KEYWORD], tracker.kind_seen[ats_pkg::KIND_IDENT],
                 tracker.kind_seen[ats_pkg::KIND_NUMBER], tracker.kind_seen[ats_pkg::KIND_STRING],
                 held_cycles);
        if (tracker.pending() != 0) begin
            $display("%0d expected results never arrived", tracker.pending());
        end
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("assembler_token_scanner verification clean");
        end else begin
            $display("%0d mismatches in total", tracker.mismatches);
            $display("assembler_token_scanner verification failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/ats_pkg.sv
hdl/assembler_token_scanner.sv
bench/tb_assembler_token_scanner.sv
